// File: hdl/ekht_pkg.sv
package ekht_pkg;

    localparam int MAX_EVENTS   = 64;
    localparam int HASH_MODULUS = 128;

    localparam int SLOT_IN_W = 6;
    localparam int SLOT_W    = $clog2(MAX_EVENTS);
    localparam int FOUND_W   = $clog2(MAX_EVENTS + 1);
    localparam int PAIR_W    = $clog2(MAX_EVENTS * (MAX_EVENTS - 1) / 2 + 1);
    localparam int KEY_W     = 32;

    localparam logic [KEY_W-1:0] EMPTY_KEY = '1;

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_STORE  = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_FREE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              occupied;
        logic [KEY_W-1:0]  key;
    } slot_entry_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [KEY_W-1:0]  key;
    } slot_write_t;

    // fold node and event numbers into an 8-bit hash; zero is kept for empty slots
    function automatic logic [7:0] key_hash_of(input logic [15:0] nn, input logic [15:0] en);
        logic [7:0] b;
        logic [7:0] e;
        logic [7:0] h;
        logic [7:0] m;
        b = nn[7:0] ^ nn[15:8];
        e = en[7:0] ^ en[15:8];
        h = (b << 3) - b + e;
        m = 8'(h % HASH_MODULUS);
        if (m == 8'd0)
            m = 8'd255;
        return m;
    endfunction

endpackage

// File: hdl/ekht_slot_store.sv
module ekht_slot_store
    import ekht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SLOT_W-1:0] rd_addr,
    output slot_entry_t       rd_entry,
    input  slot_write_t       wr
);

    logic [KEY_W-1:0]      key_mem [MAX_EVENTS];
    logic [MAX_EVENTS-1:0] written_reg;
    logic [KEY_W-1:0]      rd_key_reg;
    logic                  rd_written_reg;
    logic [KEY_W-1:0]      rd_key;

    always_ff @(posedge clk)
    begin
        if (wr.en)
            key_mem[wr.addr] <= wr.key;
        rd_key_reg <= key_mem[rd_addr];
    end

    // slot never written since reset reads as empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
                written_reg[wr.addr] <= 1'b1;
            rd_written_reg <= written_reg[rd_addr];
        end
    end

    assign rd_key            = rd_written_reg ? rd_key_reg : EMPTY_KEY;
    assign rd_entry.key      = rd_key;
    assign rd_entry.occupied = (rd_key != EMPTY_KEY);

endmodule

// File: hdl/event_key_hash_table_unit.sv
// Channel   Handshake            Payload
// input     in_valid / in_ready  kind, slot_index, event_node, event_number
// output    out_valid / out_ready found_index, hit, key_hash, event_count, collision_present
//
// Each transaction runs from acceptance to result through a scan of every slot of
// the slot memory, a drain of the read pipeline and a commit step that commits any
// write and loads the result. in_ready is high only while the sequencer idles, so a
// new transaction is accepted only once the last one has passed its commit step.
// A stalled output holds the commit step until the result register frees up.
// Reset marks every slot empty at once.
module event_key_hash_table_unit
    import ekht_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           kind,
    input  logic [SLOT_IN_W-1:0] slot_index,
    input  logic [15:0]          event_node,
    input  logic [15:0]          event_number,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [FOUND_W-1:0]   found_index,
    output logic                 hit,
    output logic [7:0]           key_hash,
    output logic [FOUND_W-1:0]   event_count,
    output logic                 collision_present
);

    // sequencer
    state_t                state_reg, state_next;
    logic [SLOT_W-1:0]     idx_reg, idx_next;
    logic                  first_reg, first_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic [SLOT_W-1:0]     cmp_idx_reg, cmp_idx_next;

    // captured transaction
    kind_t                 kind_reg, kind_next;
    logic [SLOT_IN_W-1:0]  slot_reg, slot_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [7:0]            hash_reg, hash_next;
    logic                  old_occ_reg, old_occ_next;
    logic [7:0]            old_hash_reg, old_hash_next;

    // scan accumulators
    logic [FOUND_W-1:0]    found_reg, found_next;
    logic                  found_done_reg, found_done_next;
    logic [SLOT_W-1:0]     old_match_reg, old_match_next;
    logic [SLOT_W-1:0]     new_match_reg, new_match_next;

    // table summary: number of slot pairs sharing a hash, occupied count
    logic [PAIR_W-1:0]     pair_reg, pair_next;
    logic [FOUND_W-1:0]    count_reg, count_next;

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic [FOUND_W-1:0]    found_out_reg, found_out_next;
    logic                  hit_out_reg, hit_out_next;
    logic [7:0]            hash_out_reg, hash_out_next;
    logic [FOUND_W-1:0]    count_out_reg, count_out_next;
    logic                  coll_out_reg, coll_out_next;

    logic                  accept;
    logic                  finish_go;
    logic [SLOT_W-1:0]     rd_addr;
    slot_entry_t           rd_entry;
    slot_write_t           wr;

    logic [7:0]            ent_hash;
    logic                  cmp_other;
    logic                  old_hit;
    logic                  new_hit;
    logic                  scan_cond;
    logic                  in_range;
    logic                  write_op;
    logic                  new_occ;
    logic [FOUND_W-1:0]    op_found;

    ekht_slot_store u_slot_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry),
        .wr       (wr)
    );

    // ---------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_SCAN;
            ST_SCAN:
                if (idx_reg == SLOT_W'(MAX_EVENTS - 1))
                    state_next = ST_DRAIN;
            ST_DRAIN:
                state_next = ST_FINISH;
            ST_FINISH:
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer outputs
    // ---------------------------------------------------------------
    always_comb
    begin
        in_ready  = 1'b0;
        finish_go = 1'b0;
        rd_addr   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                // fetch the addressed slot so its old contents arrive with the scan
                rd_addr  = SLOT_W'(slot_index);
            end
            ST_SCAN:
                rd_addr = idx_reg;
            ST_DRAIN:
                rd_addr = idx_reg;
            ST_FINISH:
                finish_go = !out_valid_reg || out_ready;
            default:
                rd_addr = idx_reg;
        endcase
    end

    assign accept = in_valid && in_ready;

    // ---------------------------------------------------------------
    // per-slot compare on the registered read data
    // ---------------------------------------------------------------
    assign ent_hash  = key_hash_of(rd_entry.key[31:16], rd_entry.key[15:0]);
    assign cmp_other = (cmp_idx_reg != SLOT_W'(slot_reg));
    assign old_hit   = cmp_valid_reg && cmp_other && rd_entry.occupied
                       && (ent_hash == old_hash_reg);
    assign new_hit   = cmp_valid_reg && cmp_other && rd_entry.occupied
                       && (ent_hash == hash_reg);

    always_comb
    begin
        case (kind_reg)
            KIND_LOOKUP: scan_cond = rd_entry.occupied && (rd_entry.key == key_reg);
            KIND_FREE:   scan_cond = !rd_entry.occupied;
            default:     scan_cond = 1'b0;
        endcase
    end

    assign in_range = (FOUND_W'(slot_reg) < FOUND_W'(MAX_EVENTS));
    assign write_op = ((kind_reg == KIND_STORE) || (kind_reg == KIND_CLEAR)) && in_range;
    assign new_occ  = (kind_reg == KIND_STORE) && (key_reg != EMPTY_KEY);

    always_comb
    begin
        if (write_op)
            op_found = FOUND_W'(slot_reg);
        else if ((kind_reg == KIND_LOOKUP) || (kind_reg == KIND_FREE))
            op_found = found_reg;
        else
            op_found = FOUND_W'(MAX_EVENTS);
    end

    // commit the slot write in the same cycle that loads the result
    assign wr.en   = finish_go && write_op;
    assign wr.addr = SLOT_W'(slot_reg);
    assign wr.key  = new_occ ? key_reg : EMPTY_KEY;

    // ---------------------------------------------------------------
    // datapath next values
    // ---------------------------------------------------------------
    always_comb
    begin
        idx_next        = idx_reg;
        first_next      = 1'b0;
        cmp_valid_next  = (state_reg == ST_SCAN);
        cmp_idx_next    = idx_reg;
        kind_next       = kind_reg;
        slot_next       = slot_reg;
        key_next        = key_reg;
        hash_next       = hash_reg;
        old_occ_next    = old_occ_reg;
        old_hash_next   = old_hash_reg;
        found_next      = found_reg;
        found_done_next = found_done_reg;
        old_match_next  = old_match_reg;
        new_match_next  = new_match_reg;
        pair_next       = pair_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        found_out_next  = found_out_reg;
        hit_out_next    = hit_out_reg;
        hash_out_next   = hash_out_reg;
        count_out_next  = count_out_reg;
        coll_out_next   = coll_out_reg;

        if (accept)
        begin
            // capture the transaction and clear the accumulators
            kind_next       = kind_t'(kind);
            slot_next       = slot_index;
            key_next        = {event_node, event_number};
            hash_next       = key_hash_of(event_node, event_number);
            idx_next        = '0;
            first_next      = 1'b1;
            found_next      = FOUND_W'(MAX_EVENTS);
            found_done_next = 1'b0;
            old_match_next  = '0;
            new_match_next  = '0;
        end

        if (state_reg == ST_SCAN)
            idx_next = idx_reg + SLOT_W'(1);

        if (first_reg)
        begin
            // the addressed slot, fetched at acceptance
            old_occ_next  = rd_entry.occupied;
            old_hash_next = rd_entry.occupied ? ent_hash : 8'd0;
        end

        if (cmp_valid_reg)
        begin
            if (!found_done_reg && scan_cond)
            begin
                found_next      = FOUND_W'(cmp_idx_reg);
                found_done_next = 1'b1;
            end
            if (old_hit)
                old_match_next = old_match_reg + SLOT_W'(1);
            if (new_hit)
                new_match_next = new_match_reg + SLOT_W'(1);
        end

        if (finish_go)
        begin
            if (write_op)
            begin
                pair_next = pair_reg
                            - (old_occ_reg ? PAIR_W'(old_match_reg) : PAIR_W'(0))
                            + (new_occ ? PAIR_W'(new_match_reg) : PAIR_W'(0));
                count_next = count_reg
                             - FOUND_W'(old_occ_reg)
                             + FOUND_W'(new_occ);
            end
            out_valid_next = 1'b1;
            found_out_next = op_found;
            hit_out_next   = (op_found < FOUND_W'(MAX_EVENTS));
            hash_out_next  = hash_reg;
            count_out_next = count_next;
            coll_out_next  = (pair_next != '0);
        end
    end

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            first_reg      <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            found_done_reg <= 1'b0;
            pair_reg       <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            first_reg      <= first_next;
            cmp_valid_reg  <= cmp_valid_next;
            found_done_reg <= found_done_next;
            pair_reg       <= pair_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg   <= cmp_idx_next;
        kind_reg      <= kind_next;
        slot_reg      <= slot_next;
        key_reg       <= key_next;
        hash_reg      <= hash_next;
        old_occ_reg   <= old_occ_next;
        old_hash_reg  <= old_hash_next;
        found_reg     <= found_next;
        old_match_reg <= old_match_next;
        new_match_reg <= new_match_next;
        found_out_reg <= found_out_next;
        hit_out_reg   <= hit_out_next;
        hash_out_reg  <= hash_out_next;
        count_out_reg <= count_out_next;
        coll_out_reg  <= coll_out_next;
    end

    assign out_valid         = out_valid_reg;
    assign found_index       = found_out_reg;
    assign hit               = hit_out_reg;
    assign key_hash          = hash_out_reg;
    assign event_count       = count_out_reg;
    assign collision_present = coll_out_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted again right after a transaction");

    a_hit_matches_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hit == (found_index != FOUND_W'(MAX_EVENTS))))
        else $error("hit disagrees with found_index");

    a_collision_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
        (pair_reg != '0) |-> (count_reg >= FOUND_W'(2)))
        else $error("collision tracked with fewer than two occupied slots");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FOUND_W'(MAX_EVENTS))
        else $error("occupied slot count above table size");

endmodule

// File: dv/tb_top.sv
module tb_top;
    import ekht_pkg::*;

    localparam int  RANDOM_OPS     = 1150;
    localparam int  WATCHDOG_LIMIT = 3000;
    localparam int  DRAIN_CYCLES   = 200;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    // One table operation as the sender presents it. The hold bit makes the
    // sender wait until every outstanding answer has come back.
    typedef struct packed {
        kind_t                kind;
        logic [SLOT_IN_W-1:0] slot;
        logic [15:0]          node;
        logic [15:0]          number;
        logic                 hold;
    } table_op_t;

    // One answer as the block reports it.
    typedef struct packed {
        logic [FOUND_W-1:0] found;
        logic               hit;
        logic [7:0]         hash;
        logic [FOUND_W-1:0] count;
        logic               clash;
    } table_answer_t;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_PATTERN
    } rx_mode_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_ready;
    logic [1:0]           kind         = KIND_LOOKUP;
    logic [SLOT_IN_W-1:0] slot_index   = '0;
    logic [15:0]          event_node   = '0;
    logic [15:0]          event_number = '0;
    logic                 out_valid;
    logic                 out_ready    = 1'b0;
    logic [FOUND_W-1:0]   found_index;
    logic                 hit;
    logic [7:0]           key_hash;
    logic [FOUND_W-1:0]   event_count;
    logic                 collision_present;

    // Operations waiting for the driver, and answers waiting for the block.
    table_op_t     op_queue[$];
    table_answer_t expected_answers[$];

    // Predicted table contents.
    logic [31:0] tbl_key[MAX_EVENTS];
    logic [7:0]  tbl_hash[MAX_EVENTS];
    logic        tbl_clash;

    // What the stimulus generator believes the table holds, so that it can
    // look up stored keys and aim stores at free slots.
    logic [31:0] gen_key[MAX_EVENTS];
    logic        force_hold;

    int n_ops;
    int n_accepted;
    int n_errors;

    // Driver and receiver bookkeeping.
    table_op_t cur_op;
    logic      tx_taken;
    logic      tx_start;
    int        burst_left;
    int        gap_left;
    rx_mode_t  rx_mode;
    int        rx_left;
    logic [7:0] rx_word;
    logic      rx_next;
    int        idle_cycles;

    event_key_hash_table_unit i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .kind              (kind),
        .slot_index        (slot_index),
        .event_node        (event_node),
        .event_number      (event_number),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .found_index       (found_index),
        .hit               (hit),
        .key_hash          (key_hash),
        .event_count       (event_count),
        .collision_present (collision_present)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Fold node and event number into the 8-bit bucket hash; zero is reserved
    // for empty slots, so a zero bucket maps to 255.
    function automatic logic [7:0] hash_of(input logic [15:0] nn, input logic [15:0] en);
        int unsigned b;
        int unsigned e;
        int unsigned h;
        b = (nn ^ (nn >> 8)) & 8'hff;
        e = (en ^ (en >> 8)) & 8'hff;
        h = ((7 * b + e) & 255) % HASH_MODULUS;
        if (h == 0)
            h = 255;
        return h[7:0];
    endfunction

    // Execute one accepted operation on the predicted table and queue the
    // answer the block must give for it.
    task automatic apply_table_op(input table_op_t op);
        logic [31:0]   key;
        logic [31:0]   wkey;
        logic [7:0]    h;
        logic [255:0]  seen;
        int            found;
        int            count;
        int            i;
        table_answer_t ans;
        key   = {op.node, op.number};
        h     = hash_of(op.node, op.number);
        found = MAX_EVENTS;
        case (op.kind)
            KIND_LOOKUP:
            begin
                for (i = MAX_EVENTS - 1; i >= 0; i--)
                    if (tbl_hash[i] != 8'd0 && tbl_hash[i] == h && tbl_key[i] == key)
                        found = i;
            end
            KIND_STORE, KIND_CLEAR:
            begin
                if (int'(op.slot) < MAX_EVENTS)
                begin
                    wkey = (op.kind == KIND_STORE) ? key : ALL_ONES;
                    tbl_key[op.slot]  = wkey;
                    tbl_hash[op.slot] = (wkey == ALL_ONES) ? 8'd0 :
                                        hash_of(wkey[31:16], wkey[15:0]);
                    // re-check every occupied pair for a shared hash
                    seen      = '0;
                    tbl_clash = 1'b0;
                    for (i = 0; i < MAX_EVENTS; i++)
                        if (tbl_hash[i] != 8'd0)
                        begin
                            if (seen[tbl_hash[i]])
                                tbl_clash = 1'b1;
                            seen[tbl_hash[i]] = 1'b1;
                        end
                    found = op.slot;
                end
            end
            default:
            begin
                for (i = MAX_EVENTS - 1; i >= 0; i--)
                    if (tbl_hash[i] == 8'd0)
                        found = i;
            end
        endcase
        count = 0;
        for (i = 0; i < MAX_EVENTS; i++)
            if (tbl_hash[i] != 8'd0)
                count++;
        ans.found = found[FOUND_W-1:0];
        ans.hit   = (found < MAX_EVENTS);
        ans.hash  = h;
        ans.count = count[FOUND_W-1:0];
        ans.clash = tbl_clash;
        expected_answers.push_back(ans);
    endtask

    // Compare one accepted result transaction with the oldest expected answer.
    task automatic check_answer();
        table_answer_t exp_ans;
        if (expected_answers.size() == 0)
        begin
            $error("unexpected result transaction: found_index %0d", found_index);
            n_errors++;
        end
        else
        begin
            exp_ans = expected_answers.pop_front();
            if (found_index !== exp_ans.found)
            begin
                $error("found_index: expected %0d, got %0d", exp_ans.found, found_index);
                n_errors++;
            end
            if (hit !== exp_ans.hit)
            begin
                $error("hit: expected %0d, got %0d", exp_ans.hit, hit);
                n_errors++;
            end
            if (key_hash !== exp_ans.hash)
            begin
                $error("key_hash: expected %0d, got %0d", exp_ans.hash, key_hash);
                n_errors++;
            end
            if (event_count !== exp_ans.count)
            begin
                $error("event_count: expected %0d, got %0d", exp_ans.count, event_count);
                n_errors++;
            end
            if (collision_present !== exp_ans.clash)
            begin
                $error("collision_present: expected %0d, got %0d",
                       exp_ans.clash, collision_present);
                n_errors++;
            end
        end
    endtask

    // Queue one operation and track its effect on the generator's view.
    task automatic push_op(input kind_t k, input int slot, input logic [31:0] key);
        table_op_t op;
        op.kind   = k;
        op.slot   = slot[SLOT_IN_W-1:0];
        op.node   = key[31:16];
        op.number = key[15:0];
        op.hold   = force_hold || ($urandom_range(0, 79) == 0);
        force_hold = 1'b0;
        if (k == KIND_STORE)
            gen_key[op.slot] = key;
        else if (k == KIND_CLEAR)
            gen_key[op.slot] = ALL_ONES;
        op_queue.push_back(op);
    endtask

    // Pick a random free (or occupied) slot from the generator's view; -1 if none.
    function automatic int pick_slot(input logic want_free);
        int cand[$];
        int i;
        for (i = 0; i < MAX_EVENTS; i++)
            if ((gen_key[i] == ALL_ONES) == want_free)
                cand.push_back(i);
        if (cand.size() == 0)
            return -1;
        return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    // Random non-empty key, biased toward extreme halves; optionally retry, at most
    // 40 tries, until its hash differs from every stored key.
    function automatic logic [31:0] fresh_key(input logic distinct);
        logic [31:0] k;
        logic        clash;
        int          tries;
        int          i;
        tries = 0;
        do
        begin
            k = $urandom;
            case ($urandom_range(0, 7))
                0: k[31:16] = 16'h0000;
                1: k[31:16] = 16'hFFFF;
                2: k[15:0]  = 16'h0000;
                3: k[15:0]  = 16'hFFFF;
                default: ;
            endcase
            clash = (k == ALL_ONES);
            if (distinct && !clash)
                for (i = 0; i < MAX_EVENTS; i++)
                    if (gen_key[i] != ALL_ONES &&
                        hash_of(gen_key[i][31:16], gen_key[i][15:0]) == hash_of(k[31:16], k[15:0]))
                        clash = 1'b1;
            tries++;
        end
        while (clash && tries < 40);
        if (k == ALL_ONES)
            k[0] = 1'b0;
        return k;
    endfunction

    // Store a few keys in free slots, query stored and absent keys, then search for a free slot.
    task automatic gen_populate();
        int n;
        int s;
        int i;
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++)
        begin
            s = pick_slot(1'b1);
            if (s < 0)
                s = $urandom_range(0, MAX_EVENTS - 1);
            push_op(KIND_STORE, s, fresh_key($urandom_range(0, 2) != 0));
        end
        n = $urandom_range(2, 6);
        for (i = 0; i < n; i++)
        begin
            s = pick_slot(1'b0);
            if (s >= 0 && $urandom_range(0, 4) != 0)
                push_op(KIND_LOOKUP, $urandom_range(0, 63), gen_key[s]);
            else
                push_op(KIND_LOOKUP, $urandom_range(0, 63), fresh_key(1'b0));
        end
        push_op(KIND_FREE, $urandom_range(0, 63), $urandom);
    endtask

    // Clear occupied slots, sometimes look up the key just removed, then search for a free slot.
    task automatic gen_clear();
        logic [31:0] gone;
        int n;
        int s;
        int i;
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++)
        begin
            s = pick_slot(1'b0);
            if (s < 0)
                s = $urandom_range(0, MAX_EVENTS - 1);
            gone = gen_key[s];
            push_op(KIND_CLEAR, s, $urandom);
            if ($urandom_range(0, 2) == 0)
                push_op(KIND_LOOKUP, $urandom_range(0, 63), gone);
        end
        push_op(KIND_FREE, $urandom_range(0, 63), $urandom);
    endtask

    // Store a different key with the same hash as a stored one: xor both
    // bytes of the event number with the same value to keep the fold intact.
    task automatic gen_clash();
        logic [31:0] orig;
        logic [31:0] twin;
        logic [7:0]  r;
        int s;
        int t;
        s = pick_slot(1'b0);
        if (s < 0)
        begin
            gen_populate();
            return;
        end
        orig = gen_key[s];
        r    = 8'($urandom_range(1, 255));
        twin = orig ^ {16'h0000, r, r};
        t = pick_slot(1'b1);
        if (t < 0)
            t = $urandom_range(0, MAX_EVENTS - 1);
        push_op(KIND_STORE, t, twin);
        push_op(KIND_LOOKUP, $urandom_range(0, 63), twin);
        push_op(KIND_LOOKUP, $urandom_range(0, 63), orig);
        if ($urandom_range(0, 1) == 0)
            push_op(KIND_CLEAR, t, twin);
    endtask

    // Fill every free slot, so free-slot search comes back empty.
    task automatic gen_fill();
        logic distinct;
        int i;
        int s;
        distinct = 1'($urandom_range(0, 1));
        for (i = 0; i < MAX_EVENTS; i++)
            if (gen_key[i] == ALL_ONES)
                push_op(KIND_STORE, i, fresh_key(distinct));
        push_op(KIND_FREE, $urandom_range(0, 63), $urandom);
        for (i = 0; i < 4; i++)
        begin
            s = pick_slot(1'b0);
            push_op(KIND_LOOKUP, $urandom_range(0, 63), gen_key[s]);
        end
        push_op(KIND_LOOKUP, $urandom_range(0, 63), ALL_ONES);
    endtask

    // Empty the whole table, starting at a random slot.
    task automatic gen_drain();
        int base;
        int i;
        int s;
        base = $urandom_range(0, MAX_EVENTS - 1);
        for (i = 0; i < MAX_EVENTS; i++)
        begin
            s = (base + i) % MAX_EVENTS;
            if (gen_key[s] != ALL_ONES)
                push_op(KIND_CLEAR, s, $urandom);
        end
        push_op(KIND_FREE, $urandom_range(0, 63), $urandom);
    endtask

    // Fully random operations, including stores and lookups of the all-ones key.
    task automatic gen_noise();
        logic [31:0] k;
        int n;
        int i;
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++)
        begin
            k = ($urandom_range(0, 5) == 0) ? ALL_ONES : $urandom;
            push_op(kind_t'($urandom_range(0, 3)), $urandom_range(0, 63), k);
        end
    endtask

    // Predicted table comes up empty; reset is asserted only here.
    initial
    begin
        int i;
        int pick;
        int n_directed;
        for (i = 0; i < MAX_EVENTS; i++)
        begin
            tbl_key[i]  = ALL_ONES;
            tbl_hash[i] = 8'd0;
            gen_key[i]  = ALL_ONES;
        end
        tbl_clash  = 1'b0;
        force_hold = 1'b0;
        n_accepted = 0;
        n_errors   = 0;

        // Directed: empty table, hash wrap to 255, the extreme slots, storing and
        // looking up the all-ones key, a same-hash pair and a clear of an empty slot.
        push_op(KIND_LOOKUP, 0,  ALL_ONES);
        push_op(KIND_FREE,   63, 32'h0000_0000);
        push_op(KIND_STORE,  0,  32'h0000_0000);
        push_op(KIND_STORE,  63, 32'hFFFF_FFFE);
        push_op(KIND_LOOKUP, 0,  32'hFFFF_FFFE);
        push_op(KIND_STORE,  63, ALL_ONES);
        push_op(KIND_LOOKUP, 63, ALL_ONES);
        push_op(KIND_STORE,  1,  32'h0000_0080);
        push_op(KIND_LOOKUP, 0,  32'h0000_0080);
        push_op(KIND_LOOKUP, 0,  32'h0000_0000);
        push_op(KIND_FREE,   0,  ALL_ONES);
        push_op(KIND_CLEAR,  0,  32'h0000_0000);
        push_op(KIND_CLEAR,  63, ALL_ONES);
        push_op(KIND_FREE,   21, 32'h5555_AAAA);
        push_op(KIND_LOOKUP, 42, 32'h1234_5678);
        push_op(KIND_STORE,  2,  32'hFFFF_0000);
        push_op(KIND_STORE,  32, 32'h00FF_FF00);
        push_op(KIND_LOOKUP, 0,  32'h00FF_FF00);
        push_op(KIND_CLEAR,  1,  32'hAAAA_5555);
        push_op(KIND_CLEAR,  2,  32'h0000_0000);
        push_op(KIND_CLEAR,  32, 32'hFFFF_FFFF);
        n_directed = op_queue.size();

        // Random: mostly well-formed store/query/clear sequences on a live table.
        force_hold = 1'b1;
        while (op_queue.size() < n_directed + RANDOM_OPS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                gen_populate();
            else if (pick < 60)
                gen_clear();
            else if (pick < 72)
                gen_clash();
            else if (pick < 74)
                gen_fill();
            else if (pick < 77)
                gen_drain();
            else
                gen_noise();
        end
        n_ops = op_queue.size();

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every transaction to be accepted and answered, then let
        // the block sit past its latency so a stray result shows up.
        while (n_accepted < n_ops || expected_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_answers.size() != 0)
        begin
            $error("%0d expected answers never arrived", expected_answers.size());
            n_errors++;
        end
        if (n_errors == 0)
            $display("PASS event_key_hash_table_unit");
        else
            $display("FAIL event_key_hash_table_unit");
        $finish;
    end

    // Driver: present operations in bursts of random length separated by
    // random gaps. Hold valid and payload steady until the transaction is
    // accepted; predict the answer at the accepting edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            kind         <= KIND_LOOKUP;
            slot_index   <= '0;
            event_node   <= '0;
            event_number <= '0;
            burst_left   = 1;
            gap_left     = 0;
        end
        else
        begin
            tx_taken = in_valid && in_ready;
            tx_start = 1'b0;
            if (tx_taken)
            begin
                apply_table_op(cur_op);
                n_accepted++;
            end
            if (in_valid && !tx_taken)
            begin
                // hold the pending transaction
            end
            else if (gap_left > 0)
                gap_left--;
            else if (op_queue.size() != 0 &&
                     (!op_queue[0].hold || expected_answers.size() == 0))
            begin
                // advance to the next operation; a held one waits for a quiet block
                cur_op       = op_queue.pop_front();
                tx_start     = 1'b1;
                kind         <= cur_op.kind;
                slot_index   <= cur_op.slot;
                event_node   <= cur_op.node;
                event_number <= cur_op.number;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    case ($urandom_range(0, 3))
                        0:       gap_left = 0;
                        1:       gap_left = $urandom_range(1, 6);
                        2:       gap_left = $urandom_range(10, 80);
                        default: gap_left = $urandom_range(60, 140);
                    endcase
                end
            end
            in_valid <= (in_valid && !tx_taken) || tx_start;
        end
    end

    // Monitor: check each accepted result, then pick out_ready for the next
    // cycle. The receiver switches between stall modes, one of which never
    // stalls, so back-pressure hits the commit step in varied ways.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_mode   = RX_ALWAYS;
            rx_left   = 0;
            rx_word   = 8'h01;
        end
        else
        begin
            if (out_valid && out_ready)
                check_answer();
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 300);
                rx_word = 8'($urandom);
                rx_word[0] = 1'b1;
            end
            else
                rx_left--;
            case (rx_mode)
                RX_ALWAYS: rx_next = 1'b1;
                RX_COIN:   rx_next = 1'($urandom_range(0, 1));
                RX_SPARSE: rx_next = ($urandom_range(0, 3) == 0);
                default:
                begin
                    rx_next = rx_word[0];
                    rx_word = {rx_word[0], rx_word[7:1]};
                end
            endcase
            out_ready <= rx_next;
        end
    end

    // Watchdog: drop the run if no transaction moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles = 0;
        else
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL event_key_hash_table_unit");
                $finish;
            end
        end
    end

endmodule

// File: filelist.f
hdl/ekht_pkg.sv
hdl/ekht_slot_store.sv
hdl/event_key_hash_table_unit.sv
dv/tb_top.sv
